### hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, sizes and helpers for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    // Sizes
    localparam int READY_DEPTH = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int IDX_W       = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int CNT_W       = $clog2(READY_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 10;
    localparam int OUT_W       = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    typedef logic [TIME_WIDTH-1:0] time_t;

    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_kind_t;

    // Classified request as held in the command queue
    typedef struct packed {
        cmd_kind_t          kind;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } cmd_t;

    // One ready-list entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        time_t              arrival;
    } entry_t;

    // Reported result
    typedef struct packed {
        logic               status;
        logic [ID_W-1:0]    id;
        logic [OUT_W-1:0]   arrived_at;
        logic [OUT_W-1:0]   finished_at;
        logic [OUT_W-1:0]   turnaround;
        logic [OUT_W-1:0]   waited;
        logic [OUT_W-1:0]   response;
    } result_t;

    // Low reported bits of a time value, zero-extended if time is narrower
    function automatic logic [OUT_W-1:0] to_out(input time_t t);
        logic [TIME_WIDTH+OUT_W-1:0] wide;
        wide = (TIME_WIDTH + OUT_W)'(t);
        return wide[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/nps_front.sv
// ----------------------------------------------------------------------------
// nps_front
// Accepts requests, classifies them and forwards them to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         mode,
    input  wire logic [nps_pkg::ID_W-1:0]     job_id,
    input  wire logic [nps_pkg::BURST_W-1:0]  burst_len,
    input  wire logic [nps_pkg::PRIO_W-1:0]   prio,
    input  wire logic                         q_full,
    output logic                              q_push,
    output nps_pkg::cmd_t                     q_cmd
);

    logic          stage_valid_reg;
    logic          stage_valid_next;
    nps_pkg::cmd_t stage_cmd_reg;
    nps_pkg::cmd_t classified;
    logic          accept;

    // Stage is blocked only when it holds a request and the queue is full
    assign busy   = stage_valid_reg & q_full;
    assign accept = start & ~busy;
    assign q_push = stage_valid_reg & ~q_full;
    assign q_cmd  = stage_cmd_reg;

    // Classify: decode the kind, a zero burst runs as one tick
    always_comb
    begin
        classified.kind  = mode ? nps_pkg::CMD_TICK : nps_pkg::CMD_ARRIVE;
        classified.id    = job_id;
        classified.burst = (burst_len == '0) ? nps_pkg::BURST_W'(1) : burst_len;
        classified.prio  = prio;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload stage, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cmd_reg <= classified;
        end
    end

endmodule

`default_nettype wire

### hdl/nps_queue.sv
// ----------------------------------------------------------------------------
// nps_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire nps_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output nps_pkg::cmd_t      head
);

    nps_pkg::cmd_t                 slots_reg [nps_pkg::QUEUE_DEPTH];
    logic [nps_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [nps_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [nps_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [nps_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [nps_pkg::QCNT_W-1:0]    fill_reg;
    logic [nps_pkg::QCNT_W-1:0]    fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (fill_reg == nps_pkg::QCNT_W'(nps_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    // Pointer and fill updates with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == nps_pkg::QPTR_W'(nps_pkg::QUEUE_DEPTH - 1))
                        ? '0 : nps_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == nps_pkg::QPTR_W'(nps_pkg::QUEUE_DEPTH - 1))
                        ? '0 : nps_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = nps_pkg::QCNT_W'(fill_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = nps_pkg::QCNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/nps_back.sv
// ----------------------------------------------------------------------------
// nps_back
// Executes queued requests: ready-list insert or drop, retire, priority scan, dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire nps_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               res_strobe,
    output nps_pkg::result_t   res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_REPORT = 5'b00100,
        S_SCAN   = 5'b01000,
        S_COMMIT = 5'b10000
    } back_state_t;

    back_state_t                    state_reg, state_next;
    nps_pkg::cmd_t                  cmd_reg, cmd_next;
    nps_pkg::time_t                 now_reg, now_next;
    logic                           run_active_reg, run_active_next;
    logic [nps_pkg::ID_W-1:0]       run_id_reg, run_id_next;
    nps_pkg::time_t                 run_arrival_reg, run_arrival_next;
    nps_pkg::time_t                 run_start_reg, run_start_next;
    logic [nps_pkg::BURST_W-1:0]    run_burst_reg, run_burst_next;
    logic [nps_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           retire_reg, retire_next;
    nps_pkg::time_t                 tat_reg, tat_next;
    nps_pkg::time_t                 rsp_reg, rsp_next;
    logic [nps_pkg::CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [nps_pkg::IDX_W-1:0]      best_idx_reg, best_idx_next;
    nps_pkg::entry_t                best_reg, best_next;
    logic                           strobe_reg, strobe_next;
    nps_pkg::result_t               res_reg, res_next;

    nps_pkg::entry_t                entries_reg [nps_pkg::READY_DEPTH];
    nps_pkg::entry_t                scan_entry;
    nps_pkg::entry_t                new_entry;
    nps_pkg::time_t                 elapsed;
    nps_pkg::time_t                 burst_time;
    nps_pkg::time_t                 wait_time;
    logic                           ins_en;
    logic                           shift_en;

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

    // Time arithmetic
    assign burst_time = nps_pkg::TIME_WIDTH'(run_burst_reg);
    assign elapsed    = now_reg - run_start_reg;
    assign wait_time  = tat_reg - burst_time;

    // Single scan read port
    assign scan_entry = entries_reg[scan_idx_reg[nps_pkg::IDX_W-1:0]];

    always_comb
    begin
        new_entry.id      = cmd_reg.id;
        new_entry.burst   = cmd_reg.burst;
        new_entry.prio    = cmd_reg.prio;
        new_entry.arrival = now_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        run_active_next  = run_active_reg;
        run_id_next      = run_id_reg;
        run_arrival_next = run_arrival_reg;
        run_start_next   = run_start_reg;
        run_burst_next   = run_burst_reg;
        count_next       = count_reg;
        retire_next      = retire_reg;
        tat_next         = tat_reg;
        rsp_next         = rsp_reg;
        scan_idx_next    = scan_idx_reg;
        best_idx_next    = best_idx_reg;
        best_next        = best_reg;
        strobe_next      = 1'b0;
        res_next         = res_reg;
        q_pop            = 1'b0;
        ins_en           = 1'b0;
        shift_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (cmd_reg.kind == nps_pkg::CMD_ARRIVE)
                begin
                    // Arrival: store, or report a drop when the list is full
                    if (count_reg == nps_pkg::CNT_W'(nps_pkg::READY_DEPTH))
                    begin
                        strobe_next          = 1'b1;
                        res_next.status      = nps_pkg::STATUS_DROP;
                        res_next.id          = cmd_reg.id;
                        res_next.arrived_at  = nps_pkg::to_out(now_reg);
                        res_next.finished_at = '0;
                        res_next.turnaround  = '0;
                        res_next.waited      = '0;
                        res_next.response    = '0;
                    end
                    else
                    begin
                        ins_en     = 1'b1;
                        count_next = nps_pkg::CNT_W'(count_reg + 1'b1);
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    // Tick: check for completion of the running job
                    retire_next = run_active_reg && (elapsed == burst_time);
                    tat_next    = now_reg - run_arrival_reg;
                    rsp_next    = run_start_reg - run_arrival_reg;
                    state_next  = S_REPORT;
                end
            end

            S_REPORT:
            begin
                if (retire_reg)
                begin
                    strobe_next          = 1'b1;
                    res_next.status      = nps_pkg::STATUS_DONE;
                    res_next.id          = run_id_reg;
                    res_next.arrived_at  = nps_pkg::to_out(run_arrival_reg);
                    res_next.finished_at = nps_pkg::to_out(now_reg);
                    res_next.turnaround  = nps_pkg::to_out(tat_reg);
                    res_next.waited      = nps_pkg::to_out(wait_time);
                    res_next.response    = nps_pkg::to_out(rsp_reg);
                    run_active_next      = 1'b0;
                end
                if ((!run_active_reg || retire_reg) && (count_reg != '0))
                begin
                    best_idx_next = '0;
                    best_next     = entries_reg[0];
                    scan_idx_next = nps_pkg::CNT_W'(1);
                    state_next    = S_SCAN;
                end
                else
                begin
                    now_next   = now_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // One comparison per cycle; strict less keeps the earliest on ties
                if (scan_idx_reg < count_reg)
                begin
                    if (scan_entry.prio < best_reg.prio)
                    begin
                        best_next     = scan_entry;
                        best_idx_next = scan_idx_reg[nps_pkg::IDX_W-1:0];
                    end
                    scan_idx_next = nps_pkg::CNT_W'(scan_idx_reg + 1'b1);
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end

            S_COMMIT:
            begin
                // Dispatch the chosen job and close the gap in the list
                run_id_next      = best_reg.id;
                run_burst_next   = best_reg.burst;
                run_arrival_next = best_reg.arrival;
                run_start_next   = now_reg;
                run_active_next  = 1'b1;
                shift_en         = 1'b1;
                count_next       = nps_pkg::CNT_W'(count_reg - 1'b1);
                now_next         = now_reg + 1'b1;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            now_reg         <= '0;
            run_active_reg  <= 1'b0;
            run_id_reg      <= '0;
            run_arrival_reg <= '0;
            run_start_reg   <= '0;
            run_burst_reg   <= '0;
            count_reg       <= '0;
            retire_reg      <= 1'b0;
            scan_idx_reg    <= '0;
            best_idx_reg    <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            now_reg         <= now_next;
            run_active_reg  <= run_active_next;
            run_id_reg      <= run_id_next;
            run_arrival_reg <= run_arrival_next;
            run_start_reg   <= run_start_next;
            run_burst_reg   <= run_burst_next;
            count_reg       <= count_next;
            retire_reg      <= retire_next;
            scan_idx_reg    <= scan_idx_next;
            best_idx_reg    <= best_idx_next;
            strobe_reg      <= strobe_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        tat_reg  <= tat_next;
        rsp_reg  <= rsp_next;
        best_reg <= best_next;
        res_reg  <= res_next;
    end

    // Ready list: append at the tail, shift down over the dispatched entry
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            entries_reg[count_reg[nps_pkg::IDX_W-1:0]] <= new_entry;
        end
        if (shift_en)
        begin
            for (int i = 0; i < nps_pkg::READY_DEPTH - 1; i++)
            begin
                if (nps_pkg::IDX_W'(i) >= best_idx_reg)
                begin
                    entries_reg[i] <= entries_reg[i + 1];
                end
            end
        end
    end

endmodule

`default_nettype wire

### hdl/nonpreemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// An arrival request yields a drop result if the ready list is full. A tick
// yields a completion result when the running job retires; when the unit
// goes idle with jobs ready, the tick then runs the priority scan (one
// comparator, one entry per cycle) and dispatch. The back-end sequencer
// takes one request at a time; a two-deep queue lets the front take requests
// meanwhile. Results are one-cycle strobes. Reset: asynchronous, clears time
// and the running job and empties the ready list.
// ----------------------------------------------------------------------------
`default_nettype none

module nonpreemptive_priority_scheduler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         mode,
    input  wire logic [nps_pkg::ID_W-1:0]     job_id,
    input  wire logic [nps_pkg::BURST_W-1:0]  burst_len,
    input  wire logic [nps_pkg::PRIO_W-1:0]   prio,
    output logic                              result_strobe,
    output logic                              status,
    output logic [nps_pkg::ID_W-1:0]          done_id,
    output logic [nps_pkg::OUT_W-1:0]         arrived_at,
    output logic [nps_pkg::OUT_W-1:0]         finished_at,
    output logic [nps_pkg::OUT_W-1:0]         turnaround,
    output logic [nps_pkg::OUT_W-1:0]         waited,
    output logic [nps_pkg::OUT_W-1:0]         response
);

    logic              q_full;
    logic              q_push;
    nps_pkg::cmd_t     q_cmd;
    logic              q_pop;
    logic              q_empty;
    nps_pkg::cmd_t     q_head;
    nps_pkg::result_t  res;

    // Front end: request capture and classification
    nps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .job_id    (job_id),
        .burst_len (burst_len),
        .prio      (prio),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Command queue
    nps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back end: scheduler proper
    nps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .res_strobe (result_strobe),
        .res        (res)
    );

    assign status      = res.status;
    assign done_id     = res.id;
    assign arrived_at  = res.arrived_at;
    assign finished_at = res.finished_at;
    assign turnaround  = res.turnaround;
    assign waited      = res.waited;
    assign response    = res.response;

endmodule

`default_nettype wire

### sim/tb_nonpreemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler
// Self-checking bench for the non-preemptive priority scheduler. A short
// table of requests covers the extremes first: priority ties, priorities
// above 999, a zero burst and drops from a full ready list. A random mix of
// arrivals and ticks follows. Every accepted request goes through a local
// model of the scheduler. Each result strobe is compared field by field with
// the oldest outstanding prediction. The request side idles at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nonpreemptive_priority_scheduler;

    // One row of the directed table
    typedef struct {
        nps_pkg::cmd_kind_t          kind;
        logic [nps_pkg::ID_W-1:0]    id;
        logic [nps_pkg::BURST_W-1:0] burst;
        logic [nps_pkg::PRIO_W-1:0]  prio;
        int                          reps;
        bit                          has_exp;
        nps_pkg::result_t            exp;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 700;

    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        mode  = 1'b0;
    logic [nps_pkg::ID_W-1:0]    job_id    = '0;
    logic [nps_pkg::BURST_W-1:0] burst_len = '0;
    logic [nps_pkg::PRIO_W-1:0]  prio      = '0;
    logic                        busy;
    logic                        result_strobe;
    logic                        status;
    logic [nps_pkg::ID_W-1:0]    done_id;
    logic [nps_pkg::OUT_W-1:0]   arrived_at;
    logic [nps_pkg::OUT_W-1:0]   finished_at;
    logic [nps_pkg::OUT_W-1:0]   turnaround;
    logic [nps_pkg::OUT_W-1:0]   waited;
    logic [nps_pkg::OUT_W-1:0]   response;

    // Typed expectation travelling alongside a table request
    bit               row_has_exp = 1'b0;
    nps_pkg::result_t row_exp     = '0;

    // Model state
    nps_pkg::time_t              sim_now     = '0;
    bit                          cpu_busy    = 1'b0;
    logic [nps_pkg::ID_W-1:0]    cur_id      = '0;
    nps_pkg::time_t              cur_arrival = '0;
    nps_pkg::time_t              cur_start   = '0;
    logic [nps_pkg::BURST_W-1:0] cur_burst   = '0;
    nps_pkg::entry_t             ready_list[$];

    nps_pkg::result_t due_results[$];
    int unsigned      fail_cnt = 0;
    int unsigned      item_cnt = 0;
    bit               no_idle  = 1'b0;
    stim_row_t        dir_tab[$];

    nonpreemptive_priority_scheduler u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .job_id        (job_id),
        .burst_len     (burst_len),
        .prio          (prio),
        .result_strobe (result_strobe),
        .status        (status),
        .done_id       (done_id),
        .arrived_at    (arrived_at),
        .finished_at   (finished_at),
        .turnaround    (turnaround),
        .waited        (waited),
        .response      (response)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Apply one request to the scheduler model; returns 1 when it yields a result
    function automatic bit schedule_step(input nps_pkg::cmd_kind_t kind,
                                         input logic [nps_pkg::ID_W-1:0] id,
                                         input logic [nps_pkg::BURST_W-1:0] burst,
                                         input logic [nps_pkg::PRIO_W-1:0] pr,
                                         output nps_pkg::result_t res);
        logic [nps_pkg::BURST_W-1:0] b;
        nps_pkg::time_t              tat;
        nps_pkg::entry_t             fresh;
        int                          best;
        bit                          hit;
        hit = 1'b0;
        res = '0;
        if (kind == nps_pkg::CMD_ARRIVE)
        begin
            b = (burst == '0) ? nps_pkg::BURST_W'(1) : burst;
            if (ready_list.size() >= nps_pkg::READY_DEPTH)
            begin
                res = '{status: nps_pkg::STATUS_DROP, id: id,
                        arrived_at: nps_pkg::OUT_W'(sim_now),
                        finished_at: '0, turnaround: '0, waited: '0, response: '0};
                return 1'b1;
            end
            fresh = '{id: id, burst: b, prio: pr, arrival: sim_now};
            ready_list = {ready_list, fresh};
            return 1'b0;
        end
        // retire the running job once its burst has elapsed
        if (cpu_busy && (sim_now - cur_start) == nps_pkg::time_t'(cur_burst))
        begin
            tat = sim_now - cur_arrival;
            res = '{status: nps_pkg::STATUS_DONE, id: cur_id,
                    arrived_at: nps_pkg::OUT_W'(cur_arrival),
                    finished_at: nps_pkg::OUT_W'(sim_now),
                    turnaround: nps_pkg::OUT_W'(tat),
                    waited: nps_pkg::OUT_W'(tat - nps_pkg::time_t'(cur_burst)),
                    response: nps_pkg::OUT_W'(cur_start - cur_arrival)};
            cpu_busy = 1'b0;
            hit = 1'b1;
        end
        // dispatch: lowest priority value, earliest entry on a tie
        if (!cpu_busy && ready_list.size() > 0)
        begin
            best = 0;
            for (int i = 1; i < ready_list.size(); i++)
                if (ready_list[i].prio < ready_list[best].prio)
                    best = i;
            cur_id      = ready_list[best].id;
            cur_burst   = ready_list[best].burst;
            cur_arrival = ready_list[best].arrival;
            cur_start   = sim_now;
            cpu_busy    = 1'b1;
            ready_list.delete(best);
        end
        sim_now = sim_now + 1'b1;
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [nps_pkg::OUT_W-1:0] want,
                               input logic [nps_pkg::OUT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Predict on each accepted request, check each result strobe
    always @(posedge clk)
    begin : monitor
        nps_pkg::result_t want;
        nps_pkg::result_t got;
        bit               hit;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                hit = schedule_step(nps_pkg::cmd_kind_t'(mode), job_id, burst_len, prio,
                                    want);
                if (row_has_exp)
                    due_results = {due_results, row_exp};
                else if (hit)
                    due_results = {due_results, want};
            end
            if (result_strobe)
            begin
                got = '{status: status, id: done_id, arrived_at: arrived_at,
                        finished_at: finished_at, turnaround: turnaround,
                        waited: waited, response: response};
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %0h", $time, got);
                    fail_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", nps_pkg::OUT_W'(want.status),
                                nps_pkg::OUT_W'(got.status));
                    check_field("done_id", nps_pkg::OUT_W'(want.id), nps_pkg::OUT_W'(got.id));
                    check_field("arrived_at", want.arrived_at, got.arrived_at);
                    check_field("finished_at", want.finished_at, got.finished_at);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("waited", want.waited, got.waited);
                    check_field("response", want.response, got.response);
                end
            end
        end
    end

    function automatic nps_pkg::result_t mk_res(input logic st,
                                                input logic [nps_pkg::ID_W-1:0] id,
                                                input logic [nps_pkg::OUT_W-1:0] arr,
                                                input logic [nps_pkg::OUT_W-1:0] fin,
                                                input logic [nps_pkg::OUT_W-1:0] tat,
                                                input logic [nps_pkg::OUT_W-1:0] wt,
                                                input logic [nps_pkg::OUT_W-1:0] rsp);
        return '{status: st, id: id, arrived_at: arr, finished_at: fin,
                 turnaround: tat, waited: wt, response: rsp};
    endfunction

    function automatic stim_row_t mk_row(input nps_pkg::cmd_kind_t kind,
                                         input logic [nps_pkg::ID_W-1:0] id,
                                         input logic [nps_pkg::BURST_W-1:0] burst,
                                         input logic [nps_pkg::PRIO_W-1:0] pr,
                                         input int reps,
                                         input bit has_exp, input nps_pkg::result_t exp);
        return '{kind: kind, id: id, burst: burst, prio: pr, reps: reps,
                 has_exp: has_exp, exp: exp};
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input stim_row_t row);
        dir_tab = {dir_tab, row};
    endfunction

    // Hold a request on the ports until the edge that accepts it
    task automatic issue(input nps_pkg::cmd_kind_t kind, input logic [nps_pkg::ID_W-1:0] id,
                         input logic [nps_pkg::BURST_W-1:0] burst,
                         input logic [nps_pkg::PRIO_W-1:0] pr,
                         input bit has_exp, input nps_pkg::result_t exp);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            gap = $urandom_range(0, 99);
            gap = (gap < 50) ? 0 : (gap < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= kind;
        job_id      <= id;
        burst_len   <= burst;
        prio        <= pr;
        row_has_exp <= has_exp;
        row_exp     <= exp;
        do
            @(posedge clk);
        while (busy);
        item_cnt++;
    endtask

    task automatic send_tick();
        issue(nps_pkg::CMD_TICK, nps_pkg::ID_W'($urandom_range(0, 255)),
              nps_pkg::BURST_W'($urandom_range(0, 65535)),
              nps_pkg::PRIO_W'($urandom_range(0, 1023)), 1'b0, '0);
    endtask

    // Mostly short bursts, an occasional zero
    function automatic logic [nps_pkg::BURST_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        return nps_pkg::BURST_W'((r < 16) ? $urandom_range(1, 6) : $urandom_range(7, 30));
    endfunction

    initial
    begin : stimulus
        int                        n;
        int                        sel;
        int                        tie_prio;
        logic [nps_pkg::OUT_W-1:0] t5;
        t5 = nps_pkg::OUT_W'(5);

        // Directed table: ties, priorities above 999, zero burst, full list
        add_row(mk_row(nps_pkg::CMD_TICK,   8'hFF, 16'hFFFF, 10'h3FF, 1, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_ARRIVE, 8'h00, 16'h0000, 10'h3FF, 1, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_ARRIVE, 8'hFF, 16'h0001, 10'h3FF, 1, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_ARRIVE, 8'h5A, 16'h0002, 10'h000, 1, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_TICK,   8'h00, 16'h0000, 10'h000, 1, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_TICK,   8'h00, 16'h0000, 10'h000, 1, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_TICK,   8'h00, 16'h0000, 10'h000, 1, 1'b1,
                       mk_res(nps_pkg::STATUS_DONE, 8'h5A, 1, 3, 2, 0, 0)));
        add_row(mk_row(nps_pkg::CMD_TICK,   8'h00, 16'h0000, 10'h000, 1, 1'b1,
                       mk_res(nps_pkg::STATUS_DONE, 8'h00, 1, 4, 3, 2, 2)));
        add_row(mk_row(nps_pkg::CMD_ARRIVE, 8'h80, 16'h0001, 10'h007,
                       nps_pkg::READY_DEPTH, 1'b0, '0));
        add_row(mk_row(nps_pkg::CMD_ARRIVE, 8'hC3, 16'hFFFF, 10'h3FF, 1, 1'b1,
                       mk_res(nps_pkg::STATUS_DROP, 8'hC3, t5, 0, 0, 0, 0)));
        add_row(mk_row(nps_pkg::CMD_ARRIVE, 8'h3C, 16'h8000, 10'h000, 1, 1'b1,
                       mk_res(nps_pkg::STATUS_DROP, 8'h3C, t5, 0, 0, 0, 0)));
        add_row(mk_row(nps_pkg::CMD_TICK,   8'h00, 16'h0000, 10'h000, 1, 1'b1,
                       mk_res(nps_pkg::STATUS_DONE, 8'hFF, 1, 5, 4, 3, 3)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
            for (int k = 0; k < dir_tab[r].reps; k++)
                issue(dir_tab[r].kind, dir_tab[r].id + nps_pkg::ID_W'(k), dir_tab[r].burst,
                      dir_tab[r].prio, dir_tab[r].has_exp, dir_tab[r].exp);

        // Random part: job batches then ticks, floods into a full list, noise
        n = item_cnt + RANDOM_ITEMS;
        while (item_cnt < n)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                tie_prio = $urandom_range(0, 1023);
                repeat ($urandom_range(1, 4))
                    issue(nps_pkg::CMD_ARRIVE, nps_pkg::ID_W'($urandom_range(0, 255)),
                          pick_burst(),
                          nps_pkg::PRIO_W'(($urandom_range(0, 2) == 0)
                                           ? tie_prio : $urandom_range(0, 1023)),
                          1'b0, '0);
                repeat ($urandom_range(1, 14))
                    send_tick();
            end
            else if (sel == 7)
            begin
                // past READY_DEPTH back-to-back arrivals the list is surely full
                sel = $urandom_range(nps_pkg::READY_DEPTH, nps_pkg::READY_DEPTH + 4);
                for (int k = 0; k < sel; k++)
                    issue(nps_pkg::CMD_ARRIVE, nps_pkg::ID_W'($urandom_range(0, 255)),
                          (k >= nps_pkg::READY_DEPTH)
                          ? nps_pkg::BURST_W'($urandom_range(0, 65535)) : pick_burst(),
                          nps_pkg::PRIO_W'($urandom_range(0, 1023)), 1'b0, '0);
            end
            else
            begin
                repeat ($urandom_range(3, 10))
                    if ($urandom_range(0, 1) == 0)
                        send_tick();
                    else
                        issue(nps_pkg::CMD_ARRIVE, nps_pkg::ID_W'($urandom_range(0, 255)),
                              pick_burst(), nps_pkg::PRIO_W'($urandom_range(0, 1023)),
                              1'b0, '0);
            end
        end

        // Drain outstanding results, then allow for any late strobe
        start       <= 1'b0;
        row_has_exp <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
